### rtl/hid_pkg.sv
package hid_pkg;

    // Instruction classes, in match priority order.
    typedef enum logic [4:0] {
        KIND_ADD_SUB         = 5'd0,
        KIND_SHIFT_IMM       = 5'd1,
        KIND_MOV_CMP_IMM     = 5'd2,
        KIND_ALU_OP          = 5'd3,
        KIND_BX              = 5'd4,
        KIND_HI_REG_OP       = 5'd5,
        KIND_LDR_PC_REL      = 5'd6,
        KIND_LDRH_STRH_REG   = 5'd7,
        KIND_LDRSB_LDRSH_REG = 5'd8,
        KIND_LDR_STR_REG     = 5'd9,
        KIND_LDRB_STRB_REG   = 5'd10,
        KIND_LDR_STR_IMM     = 5'd11,
        KIND_LDRB_STRB_IMM   = 5'd12,
        KIND_LDRH_STRH_IMM   = 5'd13,
        KIND_LDR_STR_SP_REL  = 5'd14,
        KIND_ADD_SP_OR_PC    = 5'd15,
        KIND_ADD_SUB_SP      = 5'd16,
        KIND_PUSH_POP        = 5'd17,
        KIND_LDM_STM         = 5'd18,
        KIND_SWI             = 5'd19,
        KIND_UNDEFINED_BCC   = 5'd20,
        KIND_BCC             = 5'd21,
        KIND_B               = 5'd22,
        KIND_BL_PREFIX       = 5'd23,
        KIND_BL_SUFFIX       = 5'd24,
        KIND_INVALID         = 5'd25
    } kind_t;

    // Decoded fields of one instruction.
    typedef struct packed {
        kind_t       kind;
        logic [3:0]  sub_op;
        logic [3:0]  dest_reg;
        logic [3:0]  src_reg;
        logic [2:0]  operand_reg;
        logic [2:0]  offset_reg;
        logic [2:0]  base_reg;
        logic [11:0] immediate;
        logic [7:0]  reg_list;
        logic [7:0]  comment_field;
        logic        flag_bit;
        logic [15:0] echo_word;
    } decode_t;

    // Class masks and patterns.
    localparam logic [15:0] MASK_F800 = 16'hF800;
    localparam logic [15:0] MASK_E000 = 16'hE000;
    localparam logic [15:0] MASK_FC00 = 16'hFC00;
    localparam logic [15:0] MASK_FF00 = 16'hFF00;
    localparam logic [15:0] MASK_F600 = 16'hF600;
    localparam logic [15:0] MASK_F000 = 16'hF000;

    localparam logic [15:0] PAT_ADD_SUB   = 16'h1800;
    localparam logic [15:0] PAT_SHIFT_IMM = 16'h0000;
    localparam logic [15:0] PAT_MOV_CMP   = 16'h2000;
    localparam logic [15:0] PAT_ALU_OP    = 16'h4000;
    localparam logic [15:0] PAT_BX        = 16'h4700;
    localparam logic [15:0] PAT_HI_REG    = 16'h4400;
    localparam logic [15:0] PAT_PC_REL    = 16'h4800;
    localparam logic [15:0] PAT_REG_XFER  = 16'h5000;
    localparam logic [15:0] PAT_WORD_IMM  = 16'h6000;
    localparam logic [15:0] PAT_BYTE_IMM  = 16'h7000;
    localparam logic [15:0] PAT_HALF_IMM  = 16'h8000;
    localparam logic [15:0] PAT_SP_REL    = 16'h9000;
    localparam logic [15:0] PAT_ADD_SP_PC = 16'hA000;
    localparam logic [15:0] PAT_ADD_SUB_SP = 16'hB000;
    localparam logic [15:0] PAT_PUSH_POP  = 16'hB400;
    localparam logic [15:0] PAT_LDM_STM   = 16'hC000;
    localparam logic [15:0] PAT_SWI       = 16'hDF00;
    localparam logic [15:0] PAT_UNDEF_BCC = 16'hDE00;
    localparam logic [15:0] PAT_BCC       = 16'hD000;
    localparam logic [15:0] PAT_B         = 16'hE000;
    localparam logic [15:0] PAT_BL_PREFIX = 16'hF000;
    localparam logic [15:0] PAT_BL_SUFFIX = 16'hF800;

    // Register-offset transfer selects, bits 10:9.
    localparam logic [1:0] XSEL_WORD  = 2'b00;
    localparam logic [1:0] XSEL_HALF  = 2'b01;
    localparam logic [1:0] XSEL_BYTE  = 2'b10;
    localparam logic [1:0] XSEL_SIGN  = 2'b11;

endpackage

### rtl/hid_decode.sv
module hid_decode
(
    input  logic [15:0]     word,
    output hid_pkg::decode_t fields
);

    always_comb
    begin
        fields               = '0;
        fields.kind          = hid_pkg::KIND_INVALID;
        fields.echo_word     = word;

        if ((word & hid_pkg::MASK_F800) == hid_pkg::PAT_ADD_SUB)
        begin
            fields.kind     = hid_pkg::KIND_ADD_SUB;
            fields.flag_bit = word[10];
            fields.sub_op   = {3'b000, word[9]};
            if (word[10])
                fields.operand_reg = word[8:6];
            else
                fields.immediate   = {9'd0, word[8:6]};
            fields.src_reg  = {1'b0, word[5:3]};
            fields.dest_reg = {1'b0, word[2:0]};
        end
        else if ((word & hid_pkg::MASK_E000) == hid_pkg::PAT_SHIFT_IMM)
        begin
            fields.kind      = hid_pkg::KIND_SHIFT_IMM;
            fields.sub_op    = {2'b00, word[12:11]};
            fields.immediate = {7'd0, word[10:6]};
            fields.src_reg   = {1'b0, word[5:3]};
            fields.dest_reg  = {1'b0, word[2:0]};
        end
        else if ((word & hid_pkg::MASK_E000) == hid_pkg::PAT_MOV_CMP)
        begin
            fields.kind      = hid_pkg::KIND_MOV_CMP_IMM;
            fields.sub_op    = {2'b00, word[12:11]};
            fields.dest_reg  = {1'b0, word[10:8]};
            fields.immediate = {4'd0, word[7:0]};
        end
        else if ((word & hid_pkg::MASK_FC00) == hid_pkg::PAT_ALU_OP)
        begin
            fields.kind     = hid_pkg::KIND_ALU_OP;
            fields.sub_op   = word[9:6];
            fields.src_reg  = {1'b0, word[5:3]};
            fields.dest_reg = {1'b0, word[2:0]};
        end
        else if ((word & hid_pkg::MASK_FF00) == hid_pkg::PAT_BX)
        begin
            fields.kind     = hid_pkg::KIND_BX;
            fields.dest_reg = {word[7], word[2:0]};
            fields.src_reg  = {word[6], word[5:3]};
        end
        else if ((word & hid_pkg::MASK_FC00) == hid_pkg::PAT_HI_REG)
        begin
            fields.kind     = hid_pkg::KIND_HI_REG_OP;
            fields.dest_reg = {word[7], word[2:0]};
            fields.src_reg  = {word[6], word[5:3]};
            fields.sub_op   = {2'b00, word[9:8]};
        end
        else if ((word & hid_pkg::MASK_F800) == hid_pkg::PAT_PC_REL)
        begin
            fields.kind      = hid_pkg::KIND_LDR_PC_REL;
            fields.dest_reg  = {1'b0, word[10:8]};
            fields.immediate = {4'd0, word[7:0]};
        end
        else if ((word & hid_pkg::MASK_F000) == hid_pkg::PAT_REG_XFER)
        begin
            // all four register-offset forms share 0x5xxx; bits 10:9 pick one
            unique case (word[10:9])
                hid_pkg::XSEL_WORD: fields.kind = hid_pkg::KIND_LDR_STR_REG;
                hid_pkg::XSEL_HALF: fields.kind = hid_pkg::KIND_LDRH_STRH_REG;
                hid_pkg::XSEL_BYTE: fields.kind = hid_pkg::KIND_LDRB_STRB_REG;
                hid_pkg::XSEL_SIGN: fields.kind = hid_pkg::KIND_LDRSB_LDRSH_REG;
                default:            fields.kind = hid_pkg::KIND_INVALID;
            endcase
            fields.flag_bit   = word[11];
            fields.offset_reg = word[8:6];
            fields.base_reg   = word[5:3];
            fields.dest_reg   = {1'b0, word[2:0]};
        end
        else if ((word & hid_pkg::MASK_F000) == hid_pkg::PAT_WORD_IMM ||
                 (word & hid_pkg::MASK_F000) == hid_pkg::PAT_BYTE_IMM ||
                 (word & hid_pkg::MASK_F000) == hid_pkg::PAT_HALF_IMM)
        begin
            if ((word & hid_pkg::MASK_F000) == hid_pkg::PAT_WORD_IMM)
                fields.kind = hid_pkg::KIND_LDR_STR_IMM;
            else if ((word & hid_pkg::MASK_F000) == hid_pkg::PAT_BYTE_IMM)
                fields.kind = hid_pkg::KIND_LDRB_STRB_IMM;
            else
                fields.kind = hid_pkg::KIND_LDRH_STRH_IMM;
            fields.flag_bit  = word[11];
            fields.immediate = {7'd0, word[10:6]};
            fields.base_reg  = word[5:3];
            fields.dest_reg  = {1'b0, word[2:0]};
        end
        else if ((word & hid_pkg::MASK_F000) == hid_pkg::PAT_SP_REL)
        begin
            fields.kind      = hid_pkg::KIND_LDR_STR_SP_REL;
            fields.flag_bit  = word[11];
            fields.dest_reg  = {1'b0, word[10:8]};
            fields.immediate = {4'd0, word[7:0]};
        end
        else if ((word & hid_pkg::MASK_F000) == hid_pkg::PAT_ADD_SP_PC)
        begin
            fields.kind      = hid_pkg::KIND_ADD_SP_OR_PC;
            fields.flag_bit  = word[11];
            fields.dest_reg  = {1'b0, word[10:8]};
            fields.immediate = {4'd0, word[7:0]};
        end
        else if ((word & hid_pkg::MASK_FF00) == hid_pkg::PAT_ADD_SUB_SP)
        begin
            fields.kind      = hid_pkg::KIND_ADD_SUB_SP;
            fields.flag_bit  = word[7];
            fields.immediate = {5'd0, word[6:0]};
        end
        else if ((word & hid_pkg::MASK_F600) == hid_pkg::PAT_PUSH_POP)
        begin
            fields.kind     = hid_pkg::KIND_PUSH_POP;
            fields.sub_op   = {3'b000, word[11]};
            fields.flag_bit = word[8];
            fields.reg_list = word[7:0];
        end
        else if ((word & hid_pkg::MASK_F000) == hid_pkg::PAT_LDM_STM)
        begin
            fields.kind     = hid_pkg::KIND_LDM_STM;
            fields.sub_op   = {3'b000, word[11]};
            fields.base_reg = word[10:8];
            fields.reg_list = word[7:0];
        end
        else if ((word & hid_pkg::MASK_FF00) == hid_pkg::PAT_SWI)
        begin
            fields.kind          = hid_pkg::KIND_SWI;
            fields.comment_field = word[7:0];
        end
        else if ((word & hid_pkg::MASK_FF00) == hid_pkg::PAT_UNDEF_BCC)
        begin
            fields.kind      = hid_pkg::KIND_UNDEFINED_BCC;
            fields.sub_op    = word[11:8];
            fields.immediate = {4'd0, word[7:0]};
        end
        else if ((word & hid_pkg::MASK_F000) == hid_pkg::PAT_BCC)
        begin
            fields.kind      = hid_pkg::KIND_BCC;
            fields.sub_op    = word[11:8];
            fields.immediate = {4'd0, word[7:0]};
        end
        else if ((word & hid_pkg::MASK_F800) == hid_pkg::PAT_B)
        begin
            fields.kind      = hid_pkg::KIND_B;
            fields.immediate = {1'b0, word[10:0]};
        end
        else if ((word & hid_pkg::MASK_F800) == hid_pkg::PAT_BL_PREFIX)
        begin
            // sign-extend the 11-bit offset
            fields.kind      = hid_pkg::KIND_BL_PREFIX;
            fields.immediate = {word[10], word[10:0]};
        end
        else if ((word & hid_pkg::MASK_F800) == hid_pkg::PAT_BL_SUFFIX)
        begin
            fields.kind      = hid_pkg::KIND_BL_SUFFIX;
            fields.immediate = {1'b0, word[10:0]};
        end
    end

endmodule

### rtl/halfword_instruction_decoder.sv
// Halfword instruction decoder.
//
// Input stream (s_axis_*): one 16-bit instruction word per transaction.
// Output stream (m_axis_*): one decoded transaction per input word, in order.
// The class code rides on m_axis_tuser; all other fields are in m_axis_tdata.
//
// Pipeline: input register -> class match and field extraction -> result
// register. m_axis_tvalid rises once a word has gone through the input and
// result registers; a stall at the output can hold it in the input register.
// Throughput is one word per cycle while the output is not stalled; both
// registers advance together when the result register is empty or being
// taken.
// Stall: when m_axis_tready is low with a result waiting, the result is
// held and the input register may still fill, so one more word is taken
// before s_axis_tready drops. Nothing is lost or repeated.
//
// Reset (rst_n low, asynchronous): both pipeline stages are emptied; the
// block is ready to accept a word as soon as reset is released.
module halfword_instruction_decoder
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] instruction

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] sub_op, [7:4] dest_reg, [11:8] src_reg, [14:12] operand_reg,
    // [17:15] offset_reg, [20:18] base_reg, [32:21] immediate,
    // [40:33] reg_list, [48:41] comment_field, [49] flag_bit,
    // [65:50] echo_word, [71:66] zero
    output logic [71:0] m_axis_tdata,
    output logic [4:0]  m_axis_tuser    // [4:0] kind
);

    logic             in_valid_reg;
    logic             in_valid_next;
    logic [15:0]      in_word_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    hid_pkg::decode_t out_reg;
    hid_pkg::decode_t decoded;
    logic             out_advance;

    // Result stage can load when empty or its content is being taken.
    assign out_advance   = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_advance;

    hid_decode u_decode
    (
        .word   (in_word_reg),
        .fields (decoded)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_advance)
            out_valid_next = in_valid_reg;
        if (s_axis_tready)
            in_valid_next = s_axis_tvalid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_word_reg <= s_axis_tdata;
        if (out_advance && in_valid_reg)
            out_reg <= decoded;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {6'd0,
                            out_reg.echo_word,
                            out_reg.flag_bit,
                            out_reg.comment_field,
                            out_reg.reg_list,
                            out_reg.immediate,
                            out_reg.base_reg,
                            out_reg.offset_reg,
                            out_reg.operand_reg,
                            out_reg.src_reg,
                            out_reg.dest_reg,
                            out_reg.sub_op};

endmodule
